FILE: src/prs128_pkg.sv
// Shared types, constants and round functions of the PRESENT-128 encryption core.
package prs128_pkg;

    localparam int BLOCK_W     = 64;
    localparam int KEY_W       = 128;
    localparam int ROUND_W     = 5;
    localparam int ROUND_COUNT = 31;
    localparam int ADDR_W      = 4;

    // Register indexes, decoded from paddr[3]
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    // Data handed from one round cell to the next
    typedef struct packed {
        logic [BLOCK_W-1:0] state;
        logic [KEY_W-1:0]   key;
        logic [ROUND_W-1:0] rnd;
    } prs128_stage_t;

    // 4-bit PRESENT S-box
    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0:    y = 4'hC;
            4'h1:    y = 4'h5;
            4'h2:    y = 4'h6;
            4'h3:    y = 4'hB;
            4'h4:    y = 4'h9;
            4'h5:    y = 4'h0;
            4'h6:    y = 4'hA;
            4'h7:    y = 4'hD;
            4'h8:    y = 4'h3;
            4'h9:    y = 4'hE;
            4'hA:    y = 4'hF;
            4'hB:    y = 4'h8;
            4'hC:    y = 4'h4;
            4'hD:    y = 4'h7;
            4'hE:    y = 4'h1;
            default: y = 4'h2;
        endcase
        return y;
    endfunction

    // Substitute every nibble of the block
    function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            y[4*n +: 4] = sbox(x[4*n +: 4]);
        end
        return y;
    endfunction

    // Bit i goes to 16*i mod 63, which is a 6-bit rotate left by four; bit 63 maps to itself
    function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        logic [5:0]         src;
        logic [5:0]         dst;
        for (int i = 0; i < BLOCK_W; i++) begin
            src    = 6'(i);
            dst    = {src[1:0], src[5:2]};
            y[dst] = x[i];
        end
        return y;
    endfunction

    // One step of the key schedule: rotate left by 61, S-box the top nibble pair,
    // add the round counter into bits 66..62
    function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                    input logic [ROUND_W-1:0] r);
        logic [KEY_W-1:0] n;
        n             = {k[66:0], k[127:67]};
        n[127:124]    = sbox(n[127:124]);
        n[123:120]    = sbox(n[123:120]);
        n[66:62]      = n[66:62] ^ r;
        return n;
    endfunction

endpackage

FILE: src/prs128_chan_if.sv
// Valid/ready channel interfaces for plaintext and ciphertext blocks.
interface prs128_plain_if;
    logic                            valid;
    logic                            ready;
    logic [prs128_pkg::BLOCK_W-1:0]  plain_block;

    modport source (output valid, output plain_block, input ready);
    modport sink   (input valid, input plain_block, output ready);
endinterface

interface prs128_cipher_if;
    logic                            valid;
    logic                            ready;
    logic [prs128_pkg::BLOCK_W-1:0]  cipher_block;

    modport source (output valid, output cipher_block, input ready);
    modport sink   (input valid, input cipher_block, output ready);
endinterface

FILE: src/prs128_round_cell.sv
// One PRESENT round cell: S-box, permutation, key schedule step and round key addition.
module prs128_round_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  prs128_pkg::prs128_stage_t up_data,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output prs128_pkg::prs128_stage_t dn_data
);

    logic                      valid_reg;
    logic                      valid_next;
    prs128_pkg::prs128_stage_t data_reg;
    prs128_pkg::prs128_stage_t data_next;
    logic                      load;
    logic [prs128_pkg::KEY_W-1:0] key_new;

    // Take a transfer when empty or when the held item leaves this cycle
    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    // Compute the round
    always_comb
    begin
        key_new         = prs128_pkg::key_update(up_data.key, up_data.rnd);
        data_next.key   = key_new;
        data_next.rnd   = up_data.rnd + prs128_pkg::ROUND_W'(1);
        data_next.state = prs128_pkg::perm_layer(prs128_pkg::sub_layer(up_data.state))
                          ^ key_new[prs128_pkg::KEY_W-1 -: prs128_pkg::BLOCK_W];
        valid_next      = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the round result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: src/prs128_key_regs.sv
// APB-style key register file holding the 128-bit cipher key.
module prs128_key_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [prs128_pkg::ADDR_W-1:0]    paddr,
    input  logic [63:0]                      pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready,
    output logic [prs128_pkg::KEY_W-1:0]     key
);

    logic [63:0] key_high_reg;
    logic [63:0] key_high_next;
    logic [63:0] key_low_reg;
    logic [63:0] key_low_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Decode the write
    always_comb
    begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        if (wr_en)
        begin
            unique case (paddr[3])
                prs128_pkg::REG_KEY_HIGH: key_high_next = pwdata;
                prs128_pkg::REG_KEY_LOW:  key_low_next  = pwdata;
                default:                  key_high_next = key_high_reg;
            endcase
        end
    end

    // Decode the read
    always_comb
    begin
        unique case (paddr[3])
            prs128_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            prs128_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else
        begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
        end
    end

    assign key = {key_high_reg, key_low_reg};

endmodule

FILE: src/present128_block_encrypt_core.sv
// Top level of the PRESENT-128 block encryption core.
// PRESENT-128 encryption core. Load the key through the APB port (key_high at
// byte address 0, key_low at 8) while no block is in flight, then stream plaintext
// blocks on the plain channel. A chain of 31 round cells, one round per cell, moves
// every block one cell per cycle while the output side is ready, and the core then
// takes one block per cycle. Each cell's register is a pipeline slot with its own
// valid flag: a stalled output fills the empty slots first, and the plain channel
// keeps taking blocks until all 31 slots hold data. Ciphertext comes out in
// plaintext order.
module present128_block_encrypt_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [prs128_pkg::ADDR_W-1:0]    paddr,
    input  logic [63:0]                      pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready,
    prs128_plain_if.sink                     plain_ch,
    prs128_cipher_if.source                  cipher_ch
);

    localparam int RC = prs128_pkg::ROUND_COUNT;

    logic [prs128_pkg::KEY_W-1:0] key;
    prs128_pkg::prs128_stage_t    chain_data  [0:RC];
    logic                         chain_valid [0:RC];
    logic                         chain_ready [0:RC];

    prs128_key_regs u_key_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key     (key)
    );

    // Feed the chain: initial key whitening, round counter starts at one
    assign chain_data[0].state = plain_ch.plain_block
                                 ^ key[prs128_pkg::KEY_W-1 -: prs128_pkg::BLOCK_W];
    assign chain_data[0].key   = key;
    assign chain_data[0].rnd   = prs128_pkg::ROUND_W'(1);
    assign chain_valid[0]      = plain_ch.valid;
    assign plain_ch.ready      = chain_ready[0];

    // Advance through the round cells
    for (genvar g = 0; g < RC; g++)
    begin : g_round
        prs128_round_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[g]),
            .up_ready (chain_ready[g]),
            .up_data  (chain_data[g]),
            .dn_valid (chain_valid[g+1]),
            .dn_ready (chain_ready[g+1]),
            .dn_data  (chain_data[g+1])
        );
    end

    // Last cell's register drives the output channel
    assign cipher_ch.valid        = chain_valid[RC];
    assign cipher_ch.cipher_block = chain_data[RC].state;
    assign chain_ready[RC]        = cipher_ch.ready;

endmodule

FILE: sim/tb_present128_block_encrypt_core.sv
// Testbench for the PRESENT-128 encryption core: directed and random blocks under several keys.
`timescale 1ns / 1ps

module tb_present128_block_encrypt_core;

    localparam int  CLK_HALF_NS   = 6;
    localparam int  RESET_CYCLES  = 12;
    localparam int  RANDOM_PHASES = 6;
    localparam int  PHASE_BLOCKS  = 100;
    localparam int  FLUSH_CYCLES  = 2 * prs128_pkg::ROUND_COUNT + 8;
    localparam int  LIMIT_NS      = 6_000_000;

    // PRESENT S-box, nibble n of the constant holds the image of n
    localparam logic [63:0] SBOX_LUT = 64'h21748FE3DA09B65C;

    localparam logic [prs128_pkg::ADDR_W-1:0] KEY_HIGH_ADDR = {prs128_pkg::REG_KEY_HIGH, 3'b000};
    localparam logic [prs128_pkg::ADDR_W-1:0] KEY_LOW_ADDR  = {prs128_pkg::REG_KEY_LOW, 3'b000};

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } key_pair_t;

    // Directed plaintexts, each run under every directed key
    localparam int DIR_PLAIN_N = 6;
    localparam logic [prs128_pkg::BLOCK_W-1:0] DIR_PLAIN [DIR_PLAIN_N] = '{
        64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0123_4567_89AB_CDEF,
        64'hFEDC_BA98_7654_3210,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA
    };

    // Directed keys; the first one is the reset value and is not written
    localparam int DIR_KEY_N = 4;
    localparam key_pair_t DIR_KEY [DIR_KEY_N] = '{
        '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000},
        '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF}
    };

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [prs128_pkg::ADDR_W-1:0]       paddr;
    logic [63:0]                         pwdata;
    logic [63:0]                         prdata;
    logic                                pready;

    prs128_plain_if  plain_bus ();
    prs128_cipher_if cipher_bus ();

    logic [prs128_pkg::KEY_W-1:0]        cur_key;
    logic [prs128_pkg::BLOCK_W-1:0]      cipher_expect [$];
    logic [prs128_pkg::BLOCK_W-1:0]      cipher_want;
    logic [63:0]                         last_rdata;
    int                                  plain_xfers;
    int                                  cipher_xfers;
    int                                  apb_xfers;
    int                                  reg_reads;
    int                                  key_settings;
    int                                  error_count;
    int                                  burst_left;
    int                                  stall_mode;
    int                                  stall_left;
    int                                  stall_tick;

    present128_block_encrypt_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .plain_ch  (plain_bus),
        .cipher_ch (cipher_bus)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Hard stop
    initial
    begin
        #LIMIT_NS;
        $display("TEST FAILED");
        $finish;
    end

    // Expected ciphertext of one block under a 128-bit key
    function automatic logic [prs128_pkg::BLOCK_W-1:0] present_encrypt(
        input logic [prs128_pkg::BLOCK_W-1:0] plain,
        input logic [prs128_pkg::KEY_W-1:0]   key);
        logic [prs128_pkg::BLOCK_W-1:0] st;
        logic [prs128_pkg::BLOCK_W-1:0] subbed;
        logic [prs128_pkg::BLOCK_W-1:0] permuted;
        logic [prs128_pkg::KEY_W-1:0]   k;
        int                             dst;
        k  = key;
        st = plain ^ k[127:64];
        for (int r = 1; r <= prs128_pkg::ROUND_COUNT; r++)
        begin
            for (int n = 0; n < 16; n++)
                subbed[4*n +: 4] = SBOX_LUT[4*st[4*n +: 4] +: 4];
            for (int i = 0; i < 64; i++)
            begin
                dst = (i == 63) ? 63 : (16 * i) % 63;
                permuted[dst] = subbed[i];
            end
            // next round key: rotate left by 61, S-box top byte, add round number
            k = (k << 61) | (k >> 67);
            k[127:124] = SBOX_LUT[4*k[127:124] +: 4];
            k[123:120] = SBOX_LUT[4*k[123:120] +: 4];
            k[66:62]   = k[66:62] ^ 5'(r);
            st = permuted ^ k[127:64];
        end
        return st;
    endfunction

    // Record transfers on all ports and check ciphertext in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (plain_bus.valid && plain_bus.ready)
            begin
                cipher_expect.push_back(present_encrypt(plain_bus.plain_block, cur_key));
                plain_xfers++;
            end
            if (cipher_bus.valid && cipher_bus.ready)
            begin
                if (cipher_expect.size() == 0)
                begin
                    $error("cipher_block: no block expected, got %h", cipher_bus.cipher_block);
                    error_count++;
                end
                else
                begin
                    cipher_want = cipher_expect.pop_front();
                    if (cipher_bus.cipher_block !== cipher_want)
                    begin
                        $error("cipher_block: expected %h, got %h",
                               cipher_want, cipher_bus.cipher_block);
                        error_count++;
                    end
                end
                cipher_xfers++;
            end
            if (psel && penable && pready)
            begin
                apb_xfers++;
                if (!pwrite)
                    last_rdata = prdata;
            end
        end
    end

    // Output backpressure: switch between stall patterns every so often
    initial cipher_bus.ready = 1'b0;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cipher_bus.ready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 120);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                0:       cipher_bus.ready <= 1'b1;
                1:       cipher_bus.ready <= ($urandom_range(0, 1) == 1);
                2:       cipher_bus.ready <= ($urandom_range(0, 7) == 0);
                default: cipher_bus.ready <= (stall_tick[2] == 1'b1);
            endcase
        end
    end

    // Offer one block, hold it until the transfer, then maybe idle a while
    task automatic send_plain(input logic [prs128_pkg::BLOCK_W-1:0] blk);
        int target;
        int gap;
        plain_bus.valid       <= 1'b1;
        plain_bus.plain_block <= blk;
        target = plain_xfers + 1;
        while (plain_xfers != target)
            @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 12);
            plain_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Drop valid and wait until every expected ciphertext has come back
    task automatic drain;
        plain_bus.valid <= 1'b0;
        while (cipher_expect.size() != 0)
            @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [prs128_pkg::ADDR_W-1:0] addr,
                              input logic [63:0] data);
        int target;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        target = apb_xfers + 1;
        while (apb_xfers != target)
            @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_reg(input logic [prs128_pkg::ADDR_W-1:0] addr,
                             input logic [63:0] want, input string field);
        apb_access(1'b0, addr, 64'h0);
        reg_reads++;
        if (last_rdata !== want)
        begin
            $error("%s: expected %h, got %h", field, want, last_rdata);
            error_count++;
        end
    endtask

    // Load a new key (core must be idle) and read it back
    task automatic load_key(input logic [63:0] high, input logic [63:0] low);
        apb_access(1'b1, KEY_HIGH_ADDR, high);
        apb_access(1'b1, KEY_LOW_ADDR, low);
        cur_key = {high, low};
        key_settings++;
        check_reg(KEY_HIGH_ADDR, high, "key_high");
        check_reg(KEY_LOW_ADDR, low, "key_low");
    endtask

    // Random plaintext mixing extremes, single-bit patterns and full random
    function automatic logic [prs128_pkg::BLOCK_W-1:0] pick_plain();
        logic [prs128_pkg::BLOCK_W-1:0] one_hot;
        one_hot = 64'h1 << $urandom_range(0, 63);
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
            1:       return one_hot;
            2:       return ~one_hot;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [63:0] pick_key_half();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Main sequence
    initial
    begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        plain_bus.valid       = 1'b0;
        plain_bus.plain_block = '0;
        cur_key               = '0;
        plain_xfers           = 0;
        cipher_xfers          = 0;
        apb_xfers             = 0;
        reg_reads             = 0;
        key_settings          = 1;
        error_count           = 0;
        burst_left            = 0;
        stall_mode            = 0;
        stall_left            = 0;
        stall_tick            = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Key registers come out of reset cleared
        check_reg(KEY_HIGH_ADDR, 64'h0, "key_high");
        check_reg(KEY_LOW_ADDR, 64'h0, "key_low");

        // Directed blocks under each extreme key
        for (int k = 0; k < DIR_KEY_N; k++)
        begin
            if (k > 0)
                load_key(DIR_KEY[k].high, DIR_KEY[k].low);
            for (int p = 0; p < DIR_PLAIN_N; p++)
                send_plain(DIR_PLAIN[p]);
            drain();
        end

        // Random blocks, a fresh key per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            load_key(pick_key_half(), pick_key_half());
            for (int b = 0; b < PHASE_BLOCKS; b++)
            begin
                // hold off once mid-phase until the pipeline has emptied
                if (ph == 2 && b == PHASE_BLOCKS / 2)
                    drain();
                send_plain(pick_plain());
            end
            drain();
        end

        repeat (FLUSH_CYCLES) @(negedge clk);

        $display("Encrypted %0d blocks under %0d keys, checked %0d ciphertexts, %0d reg reads.",
                 plain_xfers, key_settings, cipher_xfers, reg_reads);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
